@@ src/sbeu_pkg.sv @@
// Shared types, codes and defaults for the stack bytecode execute unit.
// No dependencies; the front, back and top files use it by scoped names.
package sbeu_pkg;

    localparam int unsigned DATA_DEPTH_DEF = 4096;
    localparam int unsigned IP_ADDR_DEF    = 0;
    localparam int unsigned BP_ADDR_DEF    = 1;
    localparam int unsigned SP_ADDR_DEF    = 2;
    localparam int unsigned AX_ADDR_DEF    = 3;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_EXEC,
        MODE_RESTART,
        MODE_WRITE,
        MODE_READ
    } mode_t;

    typedef enum logic [4:0] {
        OP_PUSH, OP_POP, OP_SET, OP_INC, OP_DEC, OP_JMP, OP_JZ, OP_MOV,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_ASS, OP_EQ, OP_GT,
        OP_LT, OP_AND, OP_OR, OP_NOT, OP_AG, OP_AL, OP_VAL, OP_CALL,
        OP_CAPI, OP_EXIT
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DIV0,
        ST_RANGE,
        ST_BADOP
    } status_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_WAIT,
        BS_EXEC,
        BS_DIV
    } back_state_t;

    // decoded word as it sits in the queue
    typedef struct packed {
        mode_t       mode;
        logic [4:0]  opcode;
        logic [1:0]  len;
        logic        is_alu;
        logic [31:0] a;
        logic [31:0] b;
    } item_t;

    typedef struct packed {
        logic [31:0] next_ip;
        logic [31:0] accumulator;
        logic [31:0] read_value;
        logic        api_request;
        logic [31:0] api_argument;
        logic        halted;
        status_t     status;
    } result_t;

    function automatic logic [1:0] op_len(input logic [4:0] op);
        logic [1:0] len;
        unique case (op) inside
            OP_PUSH, OP_POP, OP_JMP, OP_JZ, OP_AG, OP_AL, OP_CALL, OP_CAPI:
                len = 2'd2;
            OP_SET, OP_INC, OP_DEC, OP_MOV:
                len = 2'd3;
            default:
                len = 2'd1;
        endcase
        return len;
    endfunction

    function automatic logic op_is_alu(input logic [4:0] op);
        logic alu;
        unique case (op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_ASS, OP_EQ, OP_GT,
            OP_LT, OP_AND, OP_OR:
                alu = 1'b1;
            default:
                alu = 1'b0;
        endcase
        return alu;
    endfunction

endpackage

@@ src/sbeu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbeu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/sbeu_div.sv @@
// Signed 32-bit divider, one quotient bit per cycle, C truncating semantics.
// No dependencies.
module sbeu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = '0;
            quo_next  = dividend[31] ? -dividend : dividend;
            den_next  = divisor[31] ? -divisor : divisor;
            negq_next = dividend[31] ^ divisor[31];
            negr_next = dividend[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done      = done_reg;
    assign quotient  = negq_reg ? -quo_reg : quo_reg;
    assign remainder = negr_reg ? -rem_reg : rem_reg;

endmodule

@@ src/sbeu_front.sv @@
// Front end: accepts input words, classifies the opcode, queues the result.
// Depends on sbeu_pkg.
module sbeu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [4:0]           opcode,
    input  logic signed [31:0]   operand_a,
    input  logic signed [31:0]   operand_b,
    output logic                 q_valid,
    output sbeu_pkg::item_t      q_item,
    input  logic                 q_pop
);

    sbeu_pkg::item_t                    q_reg [sbeu_pkg::QUEUE_DEPTH];
    logic [sbeu_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [sbeu_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [sbeu_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                               push;
    logic                               pop;
    sbeu_pkg::item_t                    item_in;

    assign in_stall = (cnt_reg == sbeu_pkg::QCNT_W'(sbeu_pkg::QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        item_in.mode   = sbeu_pkg::mode_t'(mode);
        item_in.opcode = opcode;
        item_in.len    = sbeu_pkg::op_len(opcode);
        item_in.is_alu = sbeu_pkg::op_is_alu(opcode);
        item_in.a      = operand_a;
        item_in.b      = operand_b;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sbeu_pkg::QPTR_W'(sbeu_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sbeu_pkg::QPTR_W'(sbeu_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ src/sbeu_back.sv @@
// Back end: executes queued words against the data store and pointer registers.
// Depends on sbeu_pkg, sbeu_ram and sbeu_div.
module sbeu_back #(
    parameter int unsigned DATA_DEPTH = sbeu_pkg::DATA_DEPTH_DEF,
    parameter int unsigned IP_ADDR    = sbeu_pkg::IP_ADDR_DEF,
    parameter int unsigned BP_ADDR    = sbeu_pkg::BP_ADDR_DEF,
    parameter int unsigned SP_ADDR    = sbeu_pkg::SP_ADDR_DEF,
    parameter int unsigned AX_ADDR    = sbeu_pkg::AX_ADDR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sbeu_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sbeu_pkg::result_t    out_res
);

    localparam int unsigned AW = $clog2(DATA_DEPTH);
    localparam logic [31:0] IPA   = 32'(IP_ADDR);
    localparam logic [31:0] BPA   = 32'(BP_ADDR);
    localparam logic [31:0] SPA   = 32'(SP_ADDR);
    localparam logic [31:0] AXA   = 32'(AX_ADDR);
    localparam logic [31:0] DEPTH = 32'(DATA_DEPTH);

    sbeu_pkg::back_state_t state_reg, state_next;
    sbeu_pkg::item_t       cur_reg, cur_next;
    logic [31:0]           ip_reg, ip_next, bp_reg, bp_next;
    logic [31:0]           sp_reg, sp_next, ax_reg, ax_next;
    sbeu_pkg::result_t     res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;

    sbeu_pkg::op_t         op;
    logic                  is_exec;
    logic                  take;
    logic                  commit;
    logic                  div_start;
    logic                  div_done;
    logic [31:0]           div_q, div_r;
    logic                  need_div;

    logic [31:0]           adv;
    logic [31:0]           sp_m1;
    logic [31:0]           s_addr;
    logic [31:0]           rd_addr;
    logic                  addr_ok;
    logic [31:0]           ram_q;
    logic [31:0]           rv;
    logic [31:0]           x_val;
    logic [31:0]           alu_res;
    logic [31:0]           mul_res;
    sbeu_pkg::status_t     st;
    logic                  wr_ok;

    logic                  w_en   [4];
    logic [31:0]           w_addr [4];
    logic [31:0]           w_val  [4];

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [31:0]           ram_wdata;

    function automatic logic rng(input logic [31:0] v);
        return v < DEPTH;
    endfunction

    assign op      = sbeu_pkg::op_t'(cur_reg.opcode);
    assign is_exec = (cur_reg.mode == sbeu_pkg::MODE_EXEC);
    assign adv     = ip_reg + 32'(cur_reg.len);
    assign sp_m1   = sp_reg - 32'd1;
    assign x_val   = ax_reg;
    assign take    = q_valid && (!out_valid_reg || !out_stall);

    // read address and range check; pointer registers are stable until commit
    always_comb
    begin
        s_addr  = sp_reg;
        rd_addr = '0;
        addr_ok = 1'b1;
        unique case (cur_reg.mode)
            sbeu_pkg::MODE_EXEC:
            begin
                unique case (op) inside
                    sbeu_pkg::OP_PUSH:
                    begin
                        addr_ok = rng(sp_reg) && rng(cur_reg.a);
                        rd_addr = cur_reg.a;
                    end
                    sbeu_pkg::OP_POP:
                    begin
                        s_addr  = sp_m1;
                        addr_ok = rng(sp_m1) && rng(cur_reg.a);
                        rd_addr = sp_m1;
                    end
                    sbeu_pkg::OP_SET:
                    begin
                        addr_ok = rng(cur_reg.a);
                    end
                    sbeu_pkg::OP_INC, sbeu_pkg::OP_DEC:
                    begin
                        addr_ok = rng(cur_reg.a);
                        rd_addr = cur_reg.a;
                    end
                    sbeu_pkg::OP_MOV:
                    begin
                        addr_ok = rng(cur_reg.a) && rng(cur_reg.b);
                        rd_addr = cur_reg.b;
                    end
                    sbeu_pkg::OP_VAL:
                    begin
                        addr_ok = rng(ax_reg);
                        rd_addr = ax_reg;
                    end
                    sbeu_pkg::OP_CALL:
                    begin
                        rd_addr = sp_reg - cur_reg.a - 32'd1;
                        addr_ok = rng(sp_reg) && rng(rd_addr);
                    end
                    sbeu_pkg::OP_CAPI:
                    begin
                        rd_addr = sp_reg - cur_reg.a - 32'd1;
                        addr_ok = rng(rd_addr);
                    end
                    default:
                    begin
                        if (cur_reg.is_alu)
                        begin
                            s_addr  = sp_m1;
                            addr_ok = rng(sp_m1);
                            rd_addr = sp_m1;
                        end
                    end
                endcase
            end
            sbeu_pkg::MODE_WRITE:
            begin
                addr_ok = rng(cur_reg.a);
            end
            sbeu_pkg::MODE_READ:
            begin
                addr_ok = rng(cur_reg.a);
                rd_addr = cur_reg.a;
            end
            default:
            begin
                addr_ok = 1'b1;
            end
        endcase
    end

    // pointer words live in registers, the rest in the RAM
    always_comb
    begin
        if (rd_addr == IPA)
        begin
            rv = is_exec ? adv : ip_reg;
        end
        else if (rd_addr == BPA)
        begin
            rv = bp_reg;
        end
        else if (rd_addr == SPA)
        begin
            rv = sp_reg;
        end
        else if (rd_addr == AXA)
        begin
            rv = ax_reg;
        end
        else
        begin
            rv = ram_q;
        end
    end

    assign mul_res = rv * x_val;

    always_comb
    begin
        case (op)
            sbeu_pkg::OP_ADD: alu_res = rv + x_val;
            sbeu_pkg::OP_SUB: alu_res = rv - x_val;
            sbeu_pkg::OP_MUL: alu_res = mul_res;
            sbeu_pkg::OP_DIV: alu_res = div_q;
            sbeu_pkg::OP_MOD: alu_res = div_r;
            sbeu_pkg::OP_ASS: alu_res = x_val;
            sbeu_pkg::OP_EQ:  alu_res = 32'(rv == x_val);
            sbeu_pkg::OP_GT:  alu_res = 32'($signed(rv) > $signed(x_val));
            sbeu_pkg::OP_LT:  alu_res = 32'($signed(rv) < $signed(x_val));
            sbeu_pkg::OP_AND: alu_res = 32'((rv != '0) && (x_val != '0));
            default:          alu_res = 32'((rv != '0) || (x_val != '0));
        endcase
    end

    always_comb
    begin
        st = addr_ok ? sbeu_pkg::ST_OK : sbeu_pkg::ST_RANGE;
        if (is_exec && addr_ok)
        begin
            if ((op == sbeu_pkg::OP_DIV || op == sbeu_pkg::OP_MOD) && x_val == '0)
            begin
                st = sbeu_pkg::ST_DIV0;
            end
            else if (op == sbeu_pkg::OP_ASS && !rng(rv))
            begin
                st = sbeu_pkg::ST_RANGE;
            end
            else if (cur_reg.opcode > sbeu_pkg::OP_EXIT)
            begin
                st = sbeu_pkg::ST_BADOP;
            end
        end
    end

    assign wr_ok    = (st == sbeu_pkg::ST_OK) || (st == sbeu_pkg::ST_BADOP);
    assign need_div = is_exec && (st == sbeu_pkg::ST_OK) &&
                      (op == sbeu_pkg::OP_DIV || op == sbeu_pkg::OP_MOD);

    // write list in order: advanced IP, up to three more; one word in write mode
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            w_en[i]   = 1'b0;
            w_addr[i] = '0;
            w_val[i]  = '0;
        end
        if (is_exec)
        begin
            w_en[0]   = 1'b1;
            w_addr[0] = IPA;
            w_val[0]  = adv;
            case (op) inside
                sbeu_pkg::OP_PUSH:
                begin
                    w_en[1] = 1'b1; w_addr[1] = SPA;     w_val[1] = sp_reg + 32'd1;
                    w_en[2] = 1'b1; w_addr[2] = sp_reg;  w_val[2] = rv;
                end
                sbeu_pkg::OP_POP:
                begin
                    w_en[1] = 1'b1; w_addr[1] = SPA;       w_val[1] = s_addr;
                    w_en[2] = 1'b1; w_addr[2] = cur_reg.a; w_val[2] = rv;
                end
                sbeu_pkg::OP_SET:
                begin
                    w_en[1] = 1'b1; w_addr[1] = cur_reg.a; w_val[1] = cur_reg.b;
                end
                sbeu_pkg::OP_INC:
                begin
                    w_en[1] = 1'b1; w_addr[1] = cur_reg.a; w_val[1] = rv + cur_reg.b;
                end
                sbeu_pkg::OP_DEC:
                begin
                    w_en[1] = 1'b1; w_addr[1] = cur_reg.a; w_val[1] = rv - cur_reg.b;
                end
                sbeu_pkg::OP_JMP:
                begin
                    w_en[1] = 1'b1; w_addr[1] = IPA; w_val[1] = cur_reg.a;
                end
                sbeu_pkg::OP_JZ:
                begin
                    w_en[1] = (ax_reg == '0); w_addr[1] = IPA; w_val[1] = cur_reg.a;
                end
                sbeu_pkg::OP_MOV:
                begin
                    w_en[1] = 1'b1; w_addr[1] = cur_reg.a; w_val[1] = rv;
                end
                sbeu_pkg::OP_NOT:
                begin
                    w_en[1] = 1'b1; w_addr[1] = AXA; w_val[1] = 32'(ax_reg == '0);
                end
                sbeu_pkg::OP_AG:
                begin
                    w_en[1] = 1'b1; w_addr[1] = AXA; w_val[1] = cur_reg.a;
                end
                sbeu_pkg::OP_AL:
                begin
                    w_en[1] = 1'b1; w_addr[1] = AXA; w_val[1] = bp_reg + cur_reg.a;
                end
                sbeu_pkg::OP_VAL:
                begin
                    w_en[1] = 1'b1; w_addr[1] = AXA; w_val[1] = rv;
                end
                sbeu_pkg::OP_CALL:
                begin
                    w_en[1] = 1'b1; w_addr[1] = sp_reg; w_val[1] = adv;
                    w_en[2] = 1'b1; w_addr[2] = SPA;    w_val[2] = sp_reg + 32'd1;
                    w_en[3] = 1'b1; w_addr[3] = IPA;
                    // target word as seen after the push
                    if (rd_addr == SPA)
                    begin
                        w_val[3] = sp_reg + 32'd1;
                    end
                    else if (rd_addr == sp_reg)
                    begin
                        w_val[3] = adv;
                    end
                    else
                    begin
                        w_val[3] = rv;
                    end
                end
                default:
                begin
                    if (cur_reg.is_alu)
                    begin
                        w_en[1]   = 1'b1;
                        w_addr[1] = SPA;
                        w_val[1]  = s_addr;
                        w_en[2]   = 1'b1;
                        w_addr[2] = (op == sbeu_pkg::OP_ASS) ? rv : AXA;
                        w_val[2]  = alu_res;
                    end
                end
            endcase
        end
        else if (cur_reg.mode == sbeu_pkg::MODE_WRITE)
        begin
            w_en[1]   = 1'b1;
            w_addr[1] = cur_reg.a;
            w_val[1]  = cur_reg.b;
        end
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbeu_pkg::BS_IDLE: if (take) state_next = sbeu_pkg::BS_WAIT;
            sbeu_pkg::BS_WAIT: state_next = sbeu_pkg::BS_EXEC;
            sbeu_pkg::BS_EXEC: state_next = need_div ? sbeu_pkg::BS_DIV : sbeu_pkg::BS_IDLE;
            sbeu_pkg::BS_DIV:  if (div_done) state_next = sbeu_pkg::BS_IDLE;
            default:           state_next = sbeu_pkg::BS_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            sbeu_pkg::BS_IDLE: q_pop = take;
            sbeu_pkg::BS_WAIT: q_pop = 1'b0;
            sbeu_pkg::BS_EXEC:
            begin
                div_start = need_div;
                commit    = !need_div;
            end
            sbeu_pkg::BS_DIV:  commit = div_done;
            default:           q_pop = 1'b0;
        endcase
    end

    // apply the write list in order, later writes win; restart sets IP, BP, SP
    always_comb
    begin
        ip_next   = ip_reg;
        bp_next   = bp_reg;
        sp_next   = sp_reg;
        ax_next   = ax_reg;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (commit)
        begin
            if (cur_reg.mode == sbeu_pkg::MODE_RESTART)
            begin
                ip_next = '0;
                bp_next = AXA + 32'd1;
                sp_next = AXA + 32'd1;
            end
            else if (wr_ok)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (w_en[i])
                    begin
                        if (w_addr[i] == IPA)
                        begin
                            ip_next = w_val[i];
                        end
                        else if (w_addr[i] == BPA)
                        begin
                            bp_next = w_val[i];
                        end
                        else if (w_addr[i] == SPA)
                        begin
                            sp_next = w_val[i];
                        end
                        else if (w_addr[i] == AXA)
                        begin
                            ax_next = w_val[i];
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = w_addr[i][AW-1:0];
                            ram_wdata = w_val[i];
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            cur_next = q_item;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next        = 1'b1;
            res_next.next_ip      = ip_next;
            res_next.accumulator  = ax_next;
            res_next.read_value   = (cur_reg.mode == sbeu_pkg::MODE_READ && addr_ok) ?
                                    rv : '0;
            res_next.api_request  = is_exec && op == sbeu_pkg::OP_CAPI && addr_ok;
            res_next.api_argument = (is_exec && op == sbeu_pkg::OP_CAPI && addr_ok) ?
                                    rv : '0;
            res_next.halted       = is_exec && op == sbeu_pkg::OP_EXIT;
            res_next.status       = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbeu_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
            ip_reg        <= '0;
            bp_reg        <= AXA + 32'd1;
            sp_reg        <= AXA + 32'd1;
            ax_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ip_reg        <= ip_next;
            bp_reg        <= bp_next;
            sp_reg        <= sp_next;
            ax_reg        <= ax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    sbeu_ram #(
        .WIDTH (32),
        .DEPTH (DATA_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr[AW-1:0]),
        .rdata (ram_q)
    );

    sbeu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rv),
        .divisor   (x_val),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

endmodule

@@ src/stack_bytecode_execute_unit_top.sv @@
// Stack bytecode execute unit, top level.
// Each accepted word passes the front queue, then pop, registered store read and execute in the
// back end, which registers the result; DIV/MOD also run the 32-step divider.
// The back end takes a new word only once the last is done and its result output is not stalled.
// Reset: pointers set (IP 0, BP and SP just above AX, AX 0), queue and result emptied;
// data store words other than the pointers are undefined until written.
module stack_bytecode_execute_unit_top #(
    parameter int unsigned DATA_DEPTH = sbeu_pkg::DATA_DEPTH_DEF,
    parameter int unsigned IP_ADDR    = sbeu_pkg::IP_ADDR_DEF,
    parameter int unsigned BP_ADDR    = sbeu_pkg::BP_ADDR_DEF,
    parameter int unsigned SP_ADDR    = sbeu_pkg::SP_ADDR_DEF,
    parameter int unsigned AX_ADDR    = sbeu_pkg::AX_ADDR_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [4:0]          opcode,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  next_ip,
    output logic signed [31:0]  accumulator,
    output logic signed [31:0]  read_value,
    output logic                api_request,
    output logic signed [31:0]  api_argument,
    output logic                halted,
    output logic [1:0]          status
);

    logic              q_valid;
    logic              q_pop;
    sbeu_pkg::item_t   q_item;
    sbeu_pkg::result_t res;

    sbeu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    sbeu_back #(
        .DATA_DEPTH (DATA_DEPTH),
        .IP_ADDR    (IP_ADDR),
        .BP_ADDR    (BP_ADDR),
        .SP_ADDR    (SP_ADDR),
        .AX_ADDR    (AX_ADDR)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    assign next_ip      = res.next_ip;
    assign accumulator  = res.accumulator;
    assign read_value   = res.read_value;
    assign api_request  = res.api_request;
    assign api_argument = res.api_argument;
    assign halted       = res.halted;
    assign status       = res.status;

    a_fault_no_call: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sbeu_pkg::ST_RANGE || status == sbeu_pkg::ST_DIV0)
        |-> !api_request)
        else $error("host call raised on a faulted word");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_value != '0 |-> status == sbeu_pkg::ST_OK)
        else $error("read data returned with a fault");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("front stalls with an empty queue");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back popped an empty queue");

endmodule
